/* hdl/qau_pkg.sv */
package qau_pkg;

	localparam int WORD_BITS     = 32;
	localparam int FRACTION_BITS = 16;

	// operand after conjugation needs one extra bit
	localparam int OP_W  = WORD_BITS + 1;
	localparam int PR_W  = 2 * OP_W;
	localparam int HM_W  = PR_W + 2;
	localparam int LO_W  = OP_W;
	localparam int HI_W  = HM_W - LO_W;
	localparam int LP_W  = LO_W + 1 + OP_W;
	localparam int HP_W  = HI_W + OP_W;
	localparam int RP_W  = HM_W + OP_W;
	localparam int RS_W  = RP_W + 2;
	localparam int SQ_W  = 2 * WORD_BITS;
	localparam int NUM_W = 3 * WORD_BITS + 8;
	localparam int DEN_W = 2 * WORD_BITS + 2;
	localparam int DV_W  = DEN_W + 1;
	localparam int REM_W = NUM_W + 2;
	localparam int Q_W   = WORD_BITS;

	localparam logic [2:0] ACT_RMUL  = 3'd0;
	localparam logic [2:0] ACT_LMUL  = 3'd1;
	localparam logic [2:0] ACT_RDIV  = 3'd2;
	localparam logic [2:0] ACT_LDIV  = 3'd3;
	localparam logic [2:0] ACT_INV   = 3'd4;
	localparam logic [2:0] ACT_ROT   = 3'd5;
	localparam logic [2:0] ACT_SCALE = 3'd6;
	localparam logic [2:0] ACT_DIVR  = 3'd7;

	typedef logic signed [WORD_BITS-1:0] word_t;
	typedef logic signed [OP_W-1:0]      op_t;
	typedef logic signed [NUM_W-1:0]     num_t;
	typedef logic signed [DEN_W-1:0]     den_t;

	localparam den_t DEN_ONE = den_t'(1) <<< FRACTION_BITS;

	typedef struct packed {
		logic [2:0]                action;
		logic [3:0][WORD_BITS-1:0] keep;
	} ctl_t;

endpackage

/* hdl/quaternion_arithmetic_unit.sv */
// a result passes the input register, the product stages, the divider and an output register before done
// throughput: one transaction per cycle, busy stays low
// the divider uses one restoring stage per quotient bit, which sets most of the latency
// reset clears only the valid bits of the pipeline, payload registers keep old values
// the receiver cannot stall, every result is shown for exactly one cycle on done
module quaternion_arithmetic_unit import qau_pkg::*; (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [2:0]                  action,
	input  logic signed [WORD_BITS-1:0] a_real,
	input  logic signed [WORD_BITS-1:0] a_x,
	input  logic signed [WORD_BITS-1:0] a_y,
	input  logic signed [WORD_BITS-1:0] a_z,
	input  logic signed [WORD_BITS-1:0] b_real,
	input  logic signed [WORD_BITS-1:0] b_x,
	input  logic signed [WORD_BITS-1:0] b_y,
	input  logic signed [WORD_BITS-1:0] b_z,
	output logic                        done,
	output logic signed [WORD_BITS-1:0] out_real,
	output logic signed [WORD_BITS-1:0] out_x,
	output logic signed [WORD_BITS-1:0] out_y,
	output logic signed [WORD_BITS-1:0] out_z,
	output logic                        zero_divisor
);

	// operands gathered as quaternions, index 0 is the real part
	word_t a [4];
	word_t b [4];
	op_t   ca [4];
	op_t   cb [4];
	op_t   pe [4];
	op_t   qe [4];
	word_t me [4];
	ctl_t  ce;

	logic  vld_s1;
	ctl_t  ctl_s1;
	op_t   p_s1 [4];
	op_t   q_s1 [4];
	word_t m_s1 [4];
	op_t   c_s1 [4];
	word_t b0_s1;

	logic  pvld;
	ctl_t  pctl;
	num_t  pnum [4];
	den_t  pden;
	word_t res [4];

	// the pipeline never holds off a transaction
	assign busy = 1'b0;

	assign a[0] = a_real;
	assign a[1] = a_x;
	assign a[2] = a_y;
	assign a[3] = a_z;
	assign b[0] = b_real;
	assign b[1] = b_x;
	assign b[2] = b_y;
	assign b[3] = b_z;

	// operand steering: every product-like action maps onto one hamilton product, for rotation the first of two
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			ca[i] = (i == 0) ? op_t'(a[i]) : -op_t'(a[i]);
			cb[i] = (i == 0) ? op_t'(b[i]) : -op_t'(b[i]);
			pe[i] = op_t'(a[i]);
			qe[i] = op_t'(b[i]);
		end
		unique case (action)
			ACT_LMUL: begin
				for (int i = 0; i < 4; i++) begin
					pe[i] = op_t'(b[i]);
					qe[i] = op_t'(a[i]);
				end
			end
			ACT_RDIV: begin
				qe = cb;
			end
			ACT_LDIV: begin
				pe = cb;
				for (int i = 0; i < 4; i++) begin
					qe[i] = op_t'(a[i]);
				end
			end
			ACT_ROT: begin
				// rotated vector has no real part
				qe[0] = '0;
			end
			ACT_SCALE: begin
				// scalar times quaternion as a product with (b_real; 0, 0, 0)
				for (int i = 0; i < 4; i++) begin
					pe[i] = (i == 0) ? op_t'(b[0]) : '0;
					qe[i] = op_t'(a[i]);
				end
			end
			default: begin
				// plain right product, inversion and divide by real need no steering
			end
		endcase
	end

	// norm source and the operand passed through on a zero divisor
	always_comb begin
		ce.action = action;
		for (int i = 0; i < 4; i++) begin
			me[i] = ((action == ACT_RDIV) || (action == ACT_LDIV)) ? b[i] : a[i];
			if (action == ACT_ROT) begin
				ce.keep[i] = (i == 0) ? '0 : b[i];
			end else begin
				ce.keep[i] = a[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		ctl_s1 <= ce;
		p_s1   <= pe;
		q_s1   <= qe;
		m_s1   <= me;
		c_s1   <= ca;
		b0_s1  <= b[0];
	end

	// products, norm and numerator/divisor selection
	qau_prod u_prod (
		.clk    (clk),
		.arst_n (arst_n),
		.vld    (vld_s1),
		.ctl    (ctl_s1),
		.p      (p_s1),
		.q      (q_s1),
		.m      (m_s1),
		.c      (c_s1),
		.b0     (b0_s1),
		.vld_o  (pvld),
		.ctl_o  (pctl),
		.num    (pnum),
		.den    (pden)
	);

	// rounded quotient with saturation
	qau_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.vld    (pvld),
		.ctl    (pctl),
		.num    (pnum),
		.den    (pden),
		.done   (done),
		.res    (res),
		.err    (zero_divisor)
	);

	assign out_real = res[0];
	assign out_x    = res[1];
	assign out_y    = res[2];
	assign out_z    = res[3];

endmodule

/* hdl/qau_prod.sv */
module qau_prod import qau_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  vld,
	input  ctl_t  ctl,
	input  op_t   p [4],
	input  op_t   q [4],
	input  word_t m [4],
	input  op_t   c [4],
	input  word_t b0,
	output logic  vld_o,
	output ctl_t  ctl_o,
	output num_t  num [4],
	output den_t  den
);

	logic vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;
	ctl_t ctl_s2, ctl_s3, ctl_s4, ctl_s5, ctl_s6, ctl_s7;
	logic signed [PR_W-1:0] pp_s2 [4][4];
	logic signed [SQ_W-1:0] sq_s2 [4];
	op_t   c_s2 [4], c_s3 [4], c_s4 [4], c_s5 [4], c_s6 [4];
	word_t b0_s2, b0_s3, b0_s4, b0_s5, b0_s6;
	logic signed [HM_W-1:0] h_s3 [4], h_s4 [4], h_s5 [4], h_s6 [4];
	den_t  norm_s3, norm_s4, norm_s5, norm_s6;
	logic signed [LP_W-1:0] lo_s4 [4][4];
	logic signed [HP_W-1:0] hi_s4 [4][4];
	logic signed [RP_W-1:0] rp_s5 [4][4];
	logic signed [RS_W-1:0] rs_s6 [4];
	num_t  num_s7 [4];
	den_t  den_s7;
	num_t  num_d [4];
	den_t  den_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else begin
			vld_s2 <= vld;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
		end
	end

	// products of the first hamilton product and the norm squares
	always_ff @(posedge clk) begin
		ctl_s2 <= ctl;
		b0_s2  <= b0;
		for (int i = 0; i < 4; i++) begin
			c_s2[i]  <= c[i];
			sq_s2[i] <= m[i] * m[i];
			for (int j = 0; j < 4; j++) begin
				pp_s2[i][j] <= p[i] * q[j];
			end
		end
	end

	always_ff @(posedge clk) begin
		ctl_s3  <= ctl_s2;
		b0_s3   <= b0_s2;
		c_s3    <= c_s2;
		h_s3[0] <= pp_s2[0][0] - pp_s2[1][1] - pp_s2[2][2] - pp_s2[3][3];
		h_s3[1] <= pp_s2[0][1] + pp_s2[1][0] + pp_s2[2][3] - pp_s2[3][2];
		h_s3[2] <= pp_s2[0][2] + pp_s2[2][0] + pp_s2[3][1] - pp_s2[1][3];
		h_s3[3] <= pp_s2[0][3] + pp_s2[3][0] + pp_s2[1][2] - pp_s2[2][1];
		norm_s3 <= den_t'(sq_s2[0]) + den_t'(sq_s2[1]) + den_t'(sq_s2[2]) + den_t'(sq_s2[3]);
	end

	// second product for rotation, split into low and high partial products
	always_ff @(posedge clk) begin
		ctl_s4  <= ctl_s3;
		b0_s4   <= b0_s3;
		c_s4    <= c_s3;
		h_s4    <= h_s3;
		norm_s4 <= norm_s3;
		for (int i = 0; i < 4; i++) begin
			for (int j = 0; j < 4; j++) begin
				lo_s4[i][j] <= $signed({1'b0, h_s3[i][LO_W-1:0]}) * c_s3[j];
				hi_s4[i][j] <= $signed(h_s3[i][HM_W-1:LO_W]) * c_s3[j];
			end
		end
	end

	always_ff @(posedge clk) begin
		ctl_s5  <= ctl_s4;
		b0_s5   <= b0_s4;
		c_s5    <= c_s4;
		h_s5    <= h_s4;
		norm_s5 <= norm_s4;
		for (int i = 0; i < 4; i++) begin
			for (int j = 0; j < 4; j++) begin
				rp_s5[i][j] <= (RP_W'(hi_s4[i][j]) <<< LO_W) + RP_W'(lo_s4[i][j]);
			end
		end
	end

	always_ff @(posedge clk) begin
		ctl_s6   <= ctl_s5;
		b0_s6    <= b0_s5;
		c_s6     <= c_s5;
		h_s6     <= h_s5;
		norm_s6  <= norm_s5;
		rs_s6[0] <= rp_s5[0][0] - rp_s5[1][1] - rp_s5[2][2] - rp_s5[3][3];
		rs_s6[1] <= rp_s5[0][1] + rp_s5[1][0] + rp_s5[2][3] - rp_s5[3][2];
		rs_s6[2] <= rp_s5[0][2] + rp_s5[2][0] + rp_s5[3][1] - rp_s5[1][3];
		rs_s6[3] <= rp_s5[0][3] + rp_s5[3][0] + rp_s5[1][2] - rp_s5[2][1];
	end

	// numerator and divisor per action
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			unique case (ctl_s6.action)
				ACT_RDIV, ACT_LDIV: num_d[i] = num_t'(h_s6[i]) <<< FRACTION_BITS;
				ACT_INV:            num_d[i] = num_t'(c_s6[i]) <<< (2 * FRACTION_BITS);
				ACT_ROT:            num_d[i] = num_t'(rs_s6[i]);
				ACT_DIVR:           num_d[i] = num_t'($signed(ctl_s6.keep[i])) <<< FRACTION_BITS;
				default:            num_d[i] = num_t'(h_s6[i]);
			endcase
		end
		unique case (ctl_s6.action)
			ACT_RDIV, ACT_LDIV, ACT_INV, ACT_ROT: den_d = norm_s6;
			ACT_DIVR:                             den_d = den_t'(b0_s6);
			default:                              den_d = DEN_ONE;
		endcase
	end

	always_ff @(posedge clk) begin
		ctl_s7 <= ctl_s6;
		num_s7 <= num_d;
		den_s7 <= den_d;
	end

	assign vld_o = vld_s7;
	assign ctl_o = ctl_s7;
	assign num   = num_s7;
	assign den   = den_s7;

endmodule

/* hdl/qau_div.sv */
module qau_div import qau_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  vld,
	input  ctl_t  ctl,
	input  num_t  num [4],
	input  den_t  den,
	output logic  done,
	output word_t res [4],
	output logic  err
);

	localparam word_t        MAXV    = {1'b0, {(WORD_BITS-1){1'b1}}};
	localparam word_t        MINV    = {1'b1, {(WORD_BITS-1){1'b0}}};
	localparam logic [Q_W-1:0] MAG_MIN = {1'b1, {(Q_W-1){1'b0}}};

	logic             vld_sa, vld_sb;
	ctl_t             ctl_sa, ctl_sb;
	logic [3:0]       neg_sa, neg_sb;
	logic             zero_sa, zero_sb;
	logic [NUM_W-1:0] nmag_sa [4];
	logic [DEN_W-1:0] dmag_sa;
	logic [REM_W-1:0] n2_sb [4];
	logic [DV_W-1:0]  d2_sb;

	// divider stage arrays, index 0 holds the overflow check stage
	logic             dvld_s [Q_W+1];
	ctl_t             dctl_s [Q_W+1];
	logic [3:0]       dneg_s [Q_W+1];
	logic [3:0]       dovf_s [Q_W+1];
	logic             dzero_s [Q_W+1];
	logic [DV_W-1:0]  dd2_s [Q_W+1];
	logic [REM_W-1:0] drem_s [Q_W+1][4];
	logic [Q_W-1:0]   dq_s [Q_W+1][4];

	logic  done_q, err_q;
	ctl_t  ctl_q;
	word_t res_q [4];
	word_t res_d [4];
	logic  big_pos, big_neg;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sa    <= 1'b0;
			vld_sb    <= 1'b0;
			dvld_s[0] <= 1'b0;
		end else begin
			vld_sa    <= vld;
			vld_sb    <= vld_sa;
			dvld_s[0] <= vld_sb;
		end
	end

	// magnitudes and result sign
	always_ff @(posedge clk) begin
		ctl_sa  <= ctl;
		zero_sa <= (den == '0);
		dmag_sa <= den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);
		for (int i = 0; i < 4; i++) begin
			neg_sa[i]  <= num[i][NUM_W-1] ^ den[DEN_W-1];
			nmag_sa[i] <= num[i][NUM_W-1] ? NUM_W'(-num[i]) : NUM_W'(num[i]);
		end
	end

	// round half away from zero: floor((2n + d) / 2d)
	always_ff @(posedge clk) begin
		ctl_sb  <= ctl_sa;
		zero_sb <= zero_sa;
		neg_sb  <= neg_sa;
		d2_sb   <= DV_W'(dmag_sa) << 1;
		for (int i = 0; i < 4; i++) begin
			n2_sb[i] <= (REM_W'(nmag_sa[i]) << 1) + REM_W'(dmag_sa);
		end
	end

	always_ff @(posedge clk) begin
		dctl_s[0]  <= ctl_sb;
		dneg_s[0]  <= neg_sb;
		dzero_s[0] <= zero_sb;
		dd2_s[0]   <= d2_sb;
		for (int i = 0; i < 4; i++) begin
			dovf_s[0][i] <= n2_sb[i] >= (REM_W'(d2_sb) << Q_W);
			drem_s[0][i] <= n2_sb[i];
			dq_s[0][i]   <= '0;
		end
	end

	// one quotient bit per stage, most significant first
	for (genvar k = 0; k < Q_W; k++) begin : g_div
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dvld_s[k+1] <= 1'b0;
			end else begin
				dvld_s[k+1] <= dvld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			dctl_s[k+1]  <= dctl_s[k];
			dneg_s[k+1]  <= dneg_s[k];
			dovf_s[k+1]  <= dovf_s[k];
			dzero_s[k+1] <= dzero_s[k];
			dd2_s[k+1]   <= dd2_s[k];
			for (int i = 0; i < 4; i++) begin
				if (drem_s[k][i] >= (REM_W'(dd2_s[k]) << (Q_W - 1 - k))) begin
					drem_s[k+1][i] <= drem_s[k][i] - (REM_W'(dd2_s[k]) << (Q_W - 1 - k));
					dq_s[k+1][i]   <= dq_s[k][i] | (Q_W'(1) << (Q_W - 1 - k));
				end else begin
					drem_s[k+1][i] <= drem_s[k][i];
					dq_s[k+1][i]   <= dq_s[k][i];
				end
			end
		end
	end

	// sign, saturation, zero divisor pass-through and the cleared real part of a rotation
	always_comb begin
		big_pos = 1'b0;
		big_neg = 1'b0;
		for (int i = 0; i < 4; i++) begin
			big_pos = dovf_s[Q_W][i] || (dq_s[Q_W][i] > Q_W'(MAXV));
			big_neg = dovf_s[Q_W][i] || (dq_s[Q_W][i] > MAG_MIN);
			if (dzero_s[Q_W]) begin
				res_d[i] = $signed(dctl_s[Q_W].keep[i]);
			end else if (dneg_s[Q_W][i]) begin
				res_d[i] = big_neg ? MINV : word_t'(-dq_s[Q_W][i]);
			end else begin
				res_d[i] = big_pos ? MAXV : word_t'(dq_s[Q_W][i]);
			end
		end
		if (dctl_s[Q_W].action == ACT_ROT) begin
			res_d[0] = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= dvld_s[Q_W];
		end
	end

	always_ff @(posedge clk) begin
		res_q <= res_d;
		err_q <= dzero_s[Q_W];
		ctl_q <= dctl_s[Q_W];
	end

	assign done = done_q;
	assign res  = res_q;
	assign err  = err_q;

	a_rot_real_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && (ctl_q.action == ACT_ROT) |-> res_q[0] == '0)
		else $error("rotation result has nonzero real part");

	a_err_passthrough: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && err_q |-> (res_q[0] == $signed(ctl_q.keep[0])) &&
			(res_q[1] == $signed(ctl_q.keep[1])) && (res_q[2] == $signed(ctl_q.keep[2])) &&
			(res_q[3] == $signed(ctl_q.keep[3])))
		else $error("zero divisor result is not the pass-through operand");

	a_err_action: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && err_q |-> (ctl_q.action == ACT_RDIV) || (ctl_q.action == ACT_LDIV) ||
			(ctl_q.action == ACT_INV) || (ctl_q.action == ACT_ROT) ||
			(ctl_q.action == ACT_DIVR))
		else $error("zero divisor flagged on an action without division");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		dvld_s[Q_W] && !dzero_s[Q_W] |->
			(drem_s[Q_W][0] < REM_W'(dd2_s[Q_W])) && (drem_s[Q_W][1] < REM_W'(dd2_s[Q_W])) &&
			(dovf_s[Q_W][2] || (drem_s[Q_W][2] < REM_W'(dd2_s[Q_W]))) &&
			(dovf_s[Q_W][3] || (drem_s[Q_W][3] < REM_W'(dd2_s[Q_W]))) ||
			dovf_s[Q_W][0] || dovf_s[Q_W][1])
		else $error("divider remainder not below divisor");

endmodule

/* verif/quaternion_arithmetic_unit_tb.sv */
module quaternion_arithmetic_unit_tb;
	import qau_pkg::*;

	// wide enough for every exact intermediate of the rotation path
	typedef logic signed [255:0] wide_t;
	typedef wide_t quat_t [4];

	typedef struct {
		word_t q[4];
		logic  zd;
	} quat_result_t;

	class quat_scoreboard;
		quat_result_t expected_q[$];
		int errors = 0;

		function quat_t hamilton(quat_t p, quat_t q);
			quat_t r;
			int j, k;
			r[0] = p[0] * q[0] - p[1] * q[1] - p[2] * q[2] - p[3] * q[3];
			for (int i = 1; i <= 3; i++) begin
				j = i % 3 + 1;
				k = j % 3 + 1;
				r[i] = p[0] * q[i] + q[0] * p[i] + p[j] * q[k] - p[k] * q[j];
			end
			return r;
		endfunction

		function quat_t conj(quat_t p);
			quat_t r;
			r[0] = p[0];
			for (int i = 1; i <= 3; i++) r[i] = -p[i];
			return r;
		endfunction

		function wide_t norm2(quat_t p);
			return p[0] * p[0] + p[1] * p[1] + p[2] * p[2] + p[3] * p[3];
		endfunction

		// round to nearest, ties away from zero
		function wide_t round_quot(wide_t n, wide_t d);
			wide_t un, ud, q;
			un = (n < 0) ? -n : n;
			ud = (d < 0) ? -d : d;
			q = (2 * un + ud) / (2 * ud);
			return ((n < 0) != (d < 0)) ? -q : q;
		endfunction

		function word_t saturate(wide_t v);
			wide_t hi, lo;
			hi = (wide_t'(1) <<< (WORD_BITS - 1)) - wide_t'(1);
			lo = -(wide_t'(1) <<< (WORD_BITS - 1));
			if (v > hi) return 32'sh7fffffff;
			if (v < lo) return 32'sh80000000;
			return v[31:0];
		endfunction

		function void note_request(logic [2:0] act, word_t a_in[4], word_t b_in[4]);
			quat_t a, b, c, n;
			wide_t d;
			quat_result_t res;
			for (int i = 0; i < 4; i++) begin
				a[i] = wide_t'(a_in[i]);
				b[i] = wide_t'(b_in[i]);
			end
			d = wide_t'(1) <<< FRACTION_BITS;
			case (act)
				ACT_RMUL: n = hamilton(a, b);
				ACT_LMUL: n = hamilton(b, a);
				ACT_RDIV, ACT_LDIV: begin
					c = conj(b);
					n = (act == ACT_RDIV) ? hamilton(a, c) : hamilton(c, a);
					for (int i = 0; i < 4; i++) n[i] = n[i] <<< FRACTION_BITS;
					d = norm2(b);
				end
				ACT_INV: begin
					n = conj(a);
					for (int i = 0; i < 4; i++) n[i] = n[i] <<< (2 * FRACTION_BITS);
					d = norm2(a);
				end
				ACT_ROT: begin
					c = b;
					c[0] = 0;
					n = hamilton(hamilton(a, c), conj(a));
					d = norm2(a);
				end
				ACT_SCALE: for (int i = 0; i < 4; i++) n[i] = a[i] * b[0];
				default: begin
					for (int i = 0; i < 4; i++) n[i] = a[i] <<< FRACTION_BITS;
					d = b[0];
				end
			endcase
			res.zd = (d == 0);
			if (d == 0) begin
				// divisor vanished, operand passes through
				n = a;
				if (act == ACT_ROT) begin
					n = b;
					n[0] = 0;
				end
			end else begin
				for (int i = 0; i < 4; i++) n[i] = round_quot(n[i], d);
				if (act == ACT_ROT) n[0] = 0;
			end
			for (int i = 0; i < 4; i++) res.q[i] = saturate(n[i]);
			expected_q.push_back(res);
		endfunction

		function void check_result(word_t q[4], logic zd);
			quat_result_t e;
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected result %h %h %h %h zd=%b", $time,
					q[0], q[1], q[2], q[3], zd);
				errors++;
				return;
			end
			e = expected_q.pop_front();
			for (int i = 0; i < 4; i++)
				if (q[i] !== e.q[i]) begin
					$display("%0t: component %0d expected %h actual %h", $time, i, e.q[i], q[i]);
					errors++;
				end
			if (zd !== e.zd) begin
				$display("%0t: zero_divisor expected %b actual %b", $time, e.zd, zd);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic busy;
	logic [2:0] action = ACT_RMUL;
	word_t a_real = 0, a_x = 0, a_y = 0, a_z = 0;
	word_t b_real = 0, b_x = 0, b_y = 0, b_z = 0;
	logic done;
	word_t out_real, out_x, out_y, out_z;
	logic zero_divisor;

	quat_scoreboard sb;
	int idle_pct;

	quaternion_arithmetic_unit DUT (.*);

	always #5 clk = ~clk;

	// monitor: transactions in and results out, sampled at the rising edge
	always @(posedge clk) begin
		if (arst_n && sb != null) begin
			if (start && !busy)
				sb.note_request(action, '{a_real, a_x, a_y, a_z}, '{b_real, b_x, b_y, b_z});
			if (done)
				sb.check_result('{out_real, out_x, out_y, out_z}, zero_divisor);
		end
	end

	// mix of small, medium, full-range and corner values
	function automatic word_t pick_word();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return word_t'($urandom_range(0, 1 << 19)) - (1 << 18);
			4, 5: return word_t'($urandom);
			6: case ($urandom_range(0, 4))
				0: return 32'sh7fffffff;
				1: return 32'sh80000000;
				2: return 0;
				3: return 32'sh00010000;
				default: return -1;
			endcase
			default: return word_t'($urandom_range(0, 1 << 26)) - (1 << 25);
		endcase
	endfunction

	task automatic send(logic [2:0] act, word_t ar, word_t ax, word_t ay, word_t az,
			word_t br, word_t bx, word_t by, word_t bz);
		while ($urandom_range(0, 99) < idle_pct) begin
			start = 0;
			@(negedge clk);
		end
		start = 1;
		action = act;
		{a_real, a_x, a_y, a_z} = {ar, ax, ay, az};
		{b_real, b_x, b_y, b_z} = {br, bx, by, bz};
		do @(posedge clk); while (busy);
		@(negedge clk);
	endtask

	task automatic send_random();
		logic [2:0] act;
		word_t a[4], b[4];
		act = 3'($urandom_range(0, 7));
		for (int i = 0; i < 4; i++) begin
			a[i] = pick_word();
			b[i] = pick_word();
		end
		// now and then zero the divisor source, which forces a zero divisor on the dividing actions
		if ($urandom_range(0, 19) == 0) begin
			if (act == ACT_INV || act == ACT_ROT) a = '{0, 0, 0, 0};
			else if (act == ACT_DIVR) b[0] = 0;
			else b = '{0, 0, 0, 0};
		end
		send(act, a[0], a[1], a[2], a[3], b[0], b[1], b[2], b[3]);
	endtask

	initial begin
		#2_000_000;
		$display("FAIL");
		$finish;
	end

	initial begin
		int waited;
		sb = new();
		idle_pct = 0;
		repeat (8) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// directed: every action on unit-ish values, extremes, zero divisors
		for (int k = 0; k < 8; k++)
			send(k[2:0], 32'sh00010000, 32'sh00020000, -32'sh00008000, 32'sh00030000,
				32'sh00004000, -32'sh00010000, 32'sh00028000, 32'sh00001000);
		send(ACT_RMUL, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
			32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
		send(ACT_LMUL, 32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000,
			32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000);
		send(ACT_SCALE, 32'sh7fffffff, 32'sh80000000, 1, -1, 32'sh80000000, 0, 0, 0);
		send(ACT_ROT, 32'sh80000000, 32'sh7fffffff, 0, 1,
			5, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff);
		send(ACT_INV, 0, 0, 0, 1, 0, 0, 0, 0);
		send(ACT_DIVR, 32'sh7fffffff, 32'sh80000000, 3, -3, 1, 0, 0, 0);
		// zero divisor paths
		send(ACT_RDIV, 32'sh12345678, -5, 7, 32'sh80000000, 0, 0, 0, 0);
		send(ACT_LDIV, -32'sh00010000, 9, 32'sh7fffffff, 2, 0, 0, 0, 0);
		send(ACT_INV, 0, 0, 0, 0, 32'sh00010000, 1, 2, 3);
		send(ACT_ROT, 0, 0, 0, 0, 32'sh7fffffff, 32'sh80000000, -7, 32'sh00010000);
		send(ACT_DIVR, 32'sh80000000, 32'sh7fffffff, -1, 1, 0, 3, 4, 5);
		// small operands on divide by real and on a right product
		send(ACT_DIVR, 1, -1, 3, -3, 2, 0, 0, 0);
		send(ACT_RMUL, 32'sh00008000, 1, -1, 32'sh00008000, 1, 1, 1, 1);

		idle_pct = 7;
		repeat (225) send_random();
		idle_pct = 82;
		repeat (225) send_random();
		idle_pct = 0;
		repeat (225) send_random();
		start = 0;

		waited = 0;
		while (sb.expected_q.size() != 0 && waited < 10000) begin
			@(posedge clk);
			waited++;
		end
		repeat (60) @(posedge clk);
		if (sb.expected_q.size() != 0)
			$display("%0t: %0d results never arrived", $time, sb.expected_q.size());
		if (sb.errors == 0 && sb.expected_q.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule
